@@ src/nru_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nru_pkg
// Shared constants, request codes and controller/datapath interface types
// for the not-recently-used replacement unit.
// ----------------------------------------------------------------------------
package nru_pkg;

    // cache geometry
    localparam int NUM_SETS = 256;
    localparam int NUM_WAYS = 8;

    // transaction field widths
    localparam int REQ_W     = 2;
    localparam int SET_IDX_W = 8;
    localparam int WAY_W     = 3;
    localparam int RND_W     = 16;

    // derived widths
    localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int CNT_W     = $clog2(NUM_WAYS + 1);
    localparam int WAY_CMP_W = 6;

    // remainder unit: bits of the random value consumed per step
    localparam int DIV_BITS  = 8;
    localparam int DIV_ITERS = RND_W / DIV_BITS;
    localparam int DIV_CNT_W = (DIV_ITERS > 1) ? $clog2(DIV_ITERS) : 1;

    // request codes
    localparam logic [REQ_W-1:0] REQ_TOUCH      = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_INVALIDATE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_VICTIM     = 2'd3;

    // commands from the controller
    typedef struct packed {
        logic load;
        logic lookup;
        logic div_step;
        logic pick;
    } nru_cmd_t;

    // status back to the controller
    typedef struct packed {
        logic is_victim;
    } nru_status_t;

endpackage
`default_nettype wire

@@ src/nru_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nru_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ src/nru_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nru_datapath
// Recently-used bit storage, bit update, eligible-way count, remainder unit
// and k-th eligible way selection.
// ----------------------------------------------------------------------------
module nru_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire nru_pkg::nru_cmd_t           cmd,
    output nru_pkg::nru_status_t             status,
    input  wire logic [nru_pkg::REQ_W-1:0]     req_type,
    input  wire logic [nru_pkg::SET_IDX_W-1:0] set_index,
    input  wire logic [nru_pkg::WAY_W-1:0]     way,
    input  wire logic [nru_pkg::RND_W-1:0]     random_value,
    output logic      [nru_pkg::WAY_W-1:0]     victim_way,
    output logic                               bits_were_cleared
);
    import nru_pkg::*;

    // captured transaction
    logic [REQ_W-1:0]    req_reg;
    logic [SET_W-1:0]    set_reg;
    logic [WAY_W-1:0]    way_reg;
    logic [RND_W-1:0]    rnd_reg;
    logic [RND_W-1:0]    rnd_next;

    // per-set valid bits, an invalid set reads as all clear
    logic [NUM_SETS-1:0] valid_reg;
    logic                rd_valid_reg;

    // victim working state
    logic [NUM_WAYS-1:0] clear_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                cleared_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    rem_next;

    // result registers
    logic [WAY_W-1:0]    victim_reg;
    logic [WAY_W-1:0]    victim_next;
    logic                bwc_reg;

    // lookup cycle signals
    logic [SET_W-1:0]    rd_addr;
    logic [NUM_WAYS-1:0] ram_rdata;
    logic [NUM_WAYS-1:0] bits;
    logic [NUM_WAYS-1:0] way_onehot;
    logic [NUM_WAYS-1:0] upd_bits;
    logic [NUM_WAYS-1:0] clear_c;
    logic [CNT_W-1:0]    count_c;
    logic                way_ok;
    logic                is_victim;
    logic                ram_we;
    logic [NUM_WAYS-1:0] ram_wdata;

    assign rd_addr   = set_index[SET_W-1:0];
    assign is_victim = (req_reg == REQ_VICTIM);
    assign status.is_victim = is_victim;

    // bit storage
    nru_ram #(
        .WIDTH (NUM_WAYS),
        .DEPTH (NUM_SETS)
    ) u_bits_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (set_reg),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // read data and update of the set bits
    always_comb
    begin
        bits       = rd_valid_reg ? ram_rdata : '0;
        way_onehot = {{(NUM_WAYS-1){1'b0}}, 1'b1} << way_reg;
        way_ok     = ({{(WAY_CMP_W-WAY_W){1'b0}}, way_reg} < WAY_CMP_W'(NUM_WAYS));
        if (req_reg == REQ_INVALIDATE)
        begin
            upd_bits = bits & ~way_onehot;
        end
        else
        begin
            upd_bits = bits | way_onehot;
        end
    end

    // eligible ways and their count
    always_comb
    begin
        clear_c = ~bits;
        count_c = '0;
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            count_c = count_c + CNT_W'(clear_c[i]);
        end
    end

    // write back: new bits on update, all clear when a victim finds none clear
    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = upd_bits;
        if (cmd.lookup)
        begin
            if (is_victim)
            begin
                ram_we    = (count_c == '0);
                ram_wdata = '0;
            end
            else
            begin
                ram_we = way_ok;
            end
        end
    end

    // remainder step, DIV_BITS bits of the random value per cycle
    always_comb
    begin
        logic [CNT_W:0]   r;
        logic [RND_W-1:0] q;
        r = {1'b0, rem_reg};
        q = rnd_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            r = {r[CNT_W-1:0], q[RND_W-1]};
            q = q << 1;
            if (r >= {1'b0, count_reg})
            begin
                r = r - {1'b0, count_reg};
            end
        end
        rem_next = r[CNT_W-1:0];
        rnd_next = q;
    end

    // k-th eligible way in way order
    always_comb
    begin
        logic [CNT_W-1:0] pre;
        victim_next = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            pre = '0;
            for (int j = 0; j < w; j++)
            begin
                pre = pre + CNT_W'(clear_reg[j]);
            end
            if (clear_reg[w] && (pre == rem_reg))
            begin
                victim_next = WAY_W'(w);
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (ram_we)
            begin
                valid_reg[set_reg] <= 1'b1;
            end
        end
    end

    // transaction capture, victim working state and results
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_type;
            set_reg <= set_index[SET_W-1:0];
            way_reg <= way;
            rnd_reg <= random_value;
        end
        if (cmd.lookup)
        begin
            rem_reg <= '0;
            if (count_c == '0)
            begin
                clear_reg   <= '1;
                count_reg   <= CNT_W'(NUM_WAYS);
                cleared_reg <= 1'b1;
            end
            else
            begin
                clear_reg   <= clear_c;
                count_reg   <= count_c;
                cleared_reg <= 1'b0;
            end
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            rnd_reg <= rnd_next;
        end
        if (cmd.pick)
        begin
            victim_reg <= victim_next;
            bwc_reg    <= cleared_reg;
        end
    end

    assign victim_way        = victim_reg;
    assign bits_were_cleared = bwc_reg;

endmodule
`default_nettype wire

@@ src/nru_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nru_ctrl
// Sequencer: accept, set lookup, remainder steps, victim pick and the
// result strobe.
// ----------------------------------------------------------------------------
module nru_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    output logic                      done,
    output nru_pkg::nru_cmd_t         cmd,
    input  wire nru_pkg::nru_status_t status
);
    import nru_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_PICK   = 2'd3;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [DIV_CNT_W-1:0] step_reg;
    logic [DIV_CNT_W-1:0] step_next;
    logic                 done_reg;

    // commands
    always_comb
    begin
        cmd.load     = (state_reg == ST_IDLE) && start;
        cmd.lookup   = (state_reg == ST_LOOKUP);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.pick     = (state_reg == ST_PICK);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                step_next  = '0;
                state_next = status.is_victim ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == DIV_CNT_W'(DIV_ITERS - 1))
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= (state_reg == ST_PICK);
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule
`default_nettype wire

@@ src/nru_cache_replacement_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nru_cache_replacement_unit
// Not-recently-used replacement state for a set-associative cache.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Touch, insert
// and invalidate do a registered read of the set bits, then a write back,
// and give no result. A victim request goes through the set read, the
// count of clear ways, two remainder steps of 8 random bits each, and the
// pick; its result is shown for one cycle with done high, in the cycle in which
// busy falls, and must be taken then since the receiver cannot stall. The
// bit memory needs no clearing pass after reset: per-set valid bits make an
// unwritten set read as all clear, so transactions are accepted at once.
module nru_cache_replacement_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [nru_pkg::REQ_W-1:0]     req_type,
    input  wire logic [nru_pkg::SET_IDX_W-1:0] set_index,
    input  wire logic [nru_pkg::WAY_W-1:0]     way,
    input  wire logic [nru_pkg::RND_W-1:0]     random_value,
    output logic                             done,
    output logic      [nru_pkg::WAY_W-1:0]     victim_way,
    output logic                             bits_were_cleared
);
    import nru_pkg::*;

    nru_cmd_t    cmd;
    nru_status_t status;

    // sequencer
    nru_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd),
        .status (status)
    );

    // storage and arithmetic
    nru_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .req_type          (req_type),
        .set_index         (set_index),
        .way               (way),
        .random_value      (random_value),
        .victim_way        (victim_way),
        .bits_were_cleared (bits_were_cleared)
    );

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the not-recently-used replacement unit. Touch,
// insert, invalidate and victim transactions go in over start/busy; a local
// model of the per-set used bits predicts each victim pick, and every done
// strobe is compared against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import nru_pkg::*;

    // expected victim pick for one request
    typedef struct {
        logic [WAY_W-1:0] way;
        logic             cleared;
    } victim_pick_t;

    localparam int PICK_FIFO_DEPTH = 16;

    logic                 clk;
    logic                 rst_n        = 1'b0;
    logic                 start        = 1'b0;
    logic [REQ_W-1:0]     req_type     = REQ_TOUCH;
    logic [SET_IDX_W-1:0] set_index    = '0;
    logic [WAY_W-1:0]     way          = '0;
    logic [RND_W-1:0]     random_value = '0;
    logic                 busy;
    logic                 done;
    logic [WAY_W-1:0]     victim_way;
    logic                 bits_were_cleared;

    // model of the used bits and the picks still owed by the unit, oldest first
    logic [NUM_WAYS-1:0]  used_bits_model [NUM_SETS];
    victim_pick_t         pick_fifo [PICK_FIFO_DEPTH];
    int                   pick_wr = 0;
    int                   pick_rd = 0;

    int  error_count   = 0;
    int  sent_count    = 0;
    int  picks_checked = 0;
    int  full_clears   = 0;
    bit  gaps_on       = 1'b1;

    nru_cache_replacement_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .req_type          (req_type),
        .set_index         (set_index),
        .way               (way),
        .random_value      (random_value),
        .done              (done),
        .victim_way        (victim_way),
        .bits_were_cleared (bits_were_cleared)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // pick the victim among clear ways, clearing the whole set when none is clear
    function automatic victim_pick_t nru_pick_victim(input logic [NUM_WAYS-1:0] used,
                                                     input logic [RND_W-1:0] rnd);
        logic [NUM_WAYS-1:0] free_ways;
        int                  free_count;
        int                  k;
        victim_pick_t        pick;
        free_ways    = ~used;
        free_count   = $countones(free_ways);
        pick.way     = '0;
        pick.cleared = 1'b0;
        if (free_count == 0)
        begin
            free_ways    = '1;
            free_count   = NUM_WAYS;
            pick.cleared = 1'b1;
        end
        k = int'(rnd) % free_count;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (free_ways[w] && k >= 0)
            begin
                if (k == 0)
                    pick.way = WAY_W'(w);
                k--;
            end
        end
        return pick;
    endfunction

    // track accepted transactions in the model
    always @(posedge clk)
    begin
        int           s;
        victim_pick_t pick;
        if (rst_n && start && !busy)
        begin
            s = int'(set_index) % NUM_SETS;
            if (req_type == REQ_VICTIM)
            begin
                pick = nru_pick_victim(used_bits_model[s], random_value);
                if (pick.cleared)
                    used_bits_model[s] = '0;
                pick_fifo[pick_wr % PICK_FIFO_DEPTH] = pick;
                pick_wr++;
            end
            else if (int'(way) < NUM_WAYS)
            begin
                if (req_type == REQ_INVALIDATE)
                    used_bits_model[s][way] = 1'b0;
                else
                    used_bits_model[s][way] = 1'b1;
            end
        end
    end

    // check each result strobe
    always @(posedge clk)
    begin
        victim_pick_t want;
        if (rst_n && done)
        begin
            if (pick_wr == pick_rd)
            begin
                $error("unexpected result: victim_way %0d bits_were_cleared %0b",
                       victim_way, bits_were_cleared);
                error_count++;
            end
            else
            begin
                want = pick_fifo[pick_rd % PICK_FIFO_DEPTH];
                pick_rd++;
                picks_checked++;
                if (want.cleared)
                    full_clears++;
                if (victim_way !== want.way)
                begin
                    $error("victim_way: expected %0d, actual %0d", want.way, victim_way);
                    error_count++;
                end
                if (bits_were_cleared !== want.cleared)
                begin
                    $error("bits_were_cleared: expected %0b, actual %0b",
                           want.cleared, bits_were_cleared);
                    error_count++;
                end
            end
        end
    end

    // drive one transaction and hold it until the unit takes it
    task automatic send_request(input logic [REQ_W-1:0] rq, input logic [SET_IDX_W-1:0] si,
                                input logic [WAY_W-1:0] wy, input logic [RND_W-1:0] rv);
        start        <= 1'b1;
        req_type     <= rq;
        set_index    <= si;
        way          <= wy;
        random_value <= rv;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent_count++;
        // random gap before the next transaction
        if (gaps_on && $urandom_range(99) < 16)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // each request kind at the field extremes
    task automatic test_basic_requests();
        send_request(REQ_INSERT, 8'd0, 3'd0, 16'h0000);
        send_request(REQ_TOUCH, 8'd0, 3'd7, 16'hFFFF);
        send_request(REQ_TOUCH, 8'd0, 3'd7, 16'h0000);
        send_request(REQ_VICTIM, 8'd0, 3'd0, 16'h0000);
        send_request(REQ_INVALIDATE, 8'd0, 3'd0, 16'h0000);
        send_request(REQ_VICTIM, 8'd0, 3'd7, 16'h0001);
        send_request(REQ_VICTIM, 8'd255, 3'd7, 16'hFFFF);
        send_request(REQ_INVALIDATE, 8'd255, 3'd7, 16'hFFFF);
        send_request(REQ_VICTIM, 8'd128, 3'd5, 16'h8000);
    endtask

    // every way of a set used, then victim requests force and follow the clear
    task automatic test_full_set_clear();
        for (int w = 0; w < NUM_WAYS; w++)
            send_request(REQ_INSERT, 8'd255, WAY_W'(w), 16'(w));
        send_request(REQ_VICTIM, 8'd255, 3'd0, 16'hFFFF);
        send_request(REQ_VICTIM, 8'd255, 3'd0, 16'h0003);
        send_request(REQ_TOUCH, 8'd255, 3'd3, 16'h5A5A);
        send_request(REQ_VICTIM, 8'd255, 3'd0, 16'h0007);
    endtask

    // random traffic focused on a few sets so they fill up and get cleared
    task automatic test_random_traffic(input int n_items);
        logic [SET_IDX_W-1:0] hot_sets [6];
        logic [SET_IDX_W-1:0] s;
        int                   sel;
        int                   i;
        foreach (hot_sets[j])
            hot_sets[j] = SET_IDX_W'($urandom_range(0, NUM_SETS - 1));
        i = 0;
        while (i < n_items)
        begin
            // long stretch with back-to-back transactions
            gaps_on = !(i >= 250 && i < 400);
            if ($urandom_range(99) < 75)
                s = hot_sets[$urandom_range(0, 5)];
            else
                s = SET_IDX_W'($urandom_range(0, 255));
            sel = $urandom_range(99);
            if (sel < 35)
                send_request(REQ_TOUCH, s, WAY_W'($urandom_range(0, 7)),
                             RND_W'($urandom_range(0, 65535)));
            else if (sel < 55)
                send_request(REQ_INSERT, s, WAY_W'($urandom_range(0, 7)),
                             RND_W'($urandom_range(0, 65535)));
            else if (sel < 68)
                send_request(REQ_INVALIDATE, s, WAY_W'($urandom_range(0, 7)),
                             RND_W'($urandom_range(0, 65535)));
            else
            begin
                send_request(REQ_VICTIM, s, WAY_W'($urandom_range(0, 7)),
                             RND_W'($urandom_range(0, 65535)));
                // miss handling: the fill that follows the victim request
                if ($urandom_range(1) == 1)
                begin
                    send_request(REQ_INSERT, s, WAY_W'($urandom_range(0, 7)),
                                 RND_W'($urandom_range(0, 65535)));
                    i++;
                end
            end
            i++;
        end
        gaps_on = 1'b1;
    endtask

    // main sequence
    initial
    begin
        for (int s = 0; s < NUM_SETS; s++)
            used_bits_model[s] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_requests();
        test_full_set_clear();
        test_random_traffic(700);

        start <= 1'b0;
        while (pick_wr != pick_rd)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d transactions, %0d victim picks checked", sent_count,
                 picks_checked);
        $display("%0d picks came after a full set clear, %0d errors", full_clears,
                 error_count);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
